@@ rtl/quicksort_lomuto_engine_assert.svh @@
`ifndef QUICKSORT_LOMUTO_ENGINE_ASSERT_SVH
`define QUICKSORT_LOMUTO_ENGINE_ASSERT_SVH
// Assertion helpers shared by the engine.
`define QLE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define QLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/qsle_pkg.sv @@
package qsle_pkg;
    localparam int KEY_W = 64;

    function automatic logic key_less(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        logic a_nan;
        logic b_nan;
        logic a_zero;
        logic b_zero;
        logic res;
        a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
        b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
        a_zero = (a[62:0] == 63'd0);
        b_zero = (b[62:0] == 63'd0);
        if (a_nan || b_nan || (a_zero && b_zero))
            res = 1'b0;
        else if (a[63] != b[63])
            res = a[63];
        else if (a[63])
            res = (a[62:0] > b[62:0]);
        else
            res = (a[62:0] < b[62:0]);
        return res;
    endfunction
endpackage

@@ rtl/qsle_cmp.sv @@
module qsle_cmp (
    input  logic                      clk,
    input  logic [qsle_pkg::KEY_W-1:0] a,
    input  logic [qsle_pkg::KEY_W-1:0] b,
    output logic                      less
);
    import qsle_pkg::*;

    logic less_reg;

    always_ff @(posedge clk)
    begin
        less_reg <= key_less(a, b);
    end

    assign less = less_reg;
endmodule

@@ rtl/quicksort_lomuto_engine.sv @@
// Channel   Direction  Handshake                 Payload
// input     in         in_valid / in_ready       key_bits, is_last
// output    out        out_valid / out_ready     sorted_key, end_of_batch, dropped
// A key not marked last is stored while fewer than MAX_KEYS are held; later keys are dropped.
// A key marked last starts the sort: each compare of a partition steps through read,
// capture and compare, plus one more step when the pair is exchanged.
// Emission then reads, captures and presents one key at a time.
// Reset clears the control state; the key memory and range stack hold no reset value.
// The output holds while out_ready is low; no input is taken until the batch is emitted.
module quicksort_lomuto_engine #(
    parameter int MAX_KEYS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] key_bits,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] sorted_key,
    output logic        end_of_batch,
    output logic        dropped
);
    import qsle_pkg::*;

    localparam int IW = (MAX_KEYS <= 2) ? 1 : $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_POP, S_RDP, S_PIV, S_RDJ, S_CMP, S_SWI, S_SWJ,
        S_FIN1, S_FIN2, S_PUSH, S_ERD, S_EWAIT, S_OUT
    } state_t;

    state_t state_reg;
    logic [KEY_W-1:0] mem [MAX_KEYS];
    logic [CW-1:0] count_reg;
    logic          ovf_reg;
    logic [2*IW-1:0] stk [MAX_KEYS];
    logic [CW-1:0] sp_reg;
    logic [IW-1:0] lo_reg, hi_reg, i_reg, j_reg;
    logic [KEY_W-1:0] piv_reg, rd_reg, aj_reg;
    logic [IW-1:0] emit_reg;
    logic [KEY_W-1:0] out_key_reg;
    logic out_valid_reg, out_last_reg;
    logic less;
    logic [KEY_W-1:0] rdata;
    logic [IW-1:0] raddr;
    logic [2*IW-1:0] stk_top;
    logic has_l, has_r;
    logic [IW:0] lsz, rsz;

    qsle_cmp u_cmp (.clk(clk), .a(rdata), .b(piv_reg), .less(less));

    assign rdata = rd_reg;
    assign in_ready = (state_reg == S_LOAD);
    assign out_valid = out_valid_reg;
    assign sorted_key = out_key_reg;
    assign end_of_batch = out_last_reg;
    assign dropped = ovf_reg;
    assign has_l = i_reg > lo_reg + IW'(1) && i_reg != '0;
    assign has_r = hi_reg > i_reg + IW'(1) && i_reg != IW'(MAX_KEYS - 1);
    assign lsz = {1'b0, i_reg} - {1'b0, lo_reg};
    assign rsz = {1'b0, hi_reg} - {1'b0, i_reg};

    always_comb
    begin
        unique case (state_reg)
            S_RDP:   raddr = stk_top[IW-1:0];
            S_RDJ:   raddr = j_reg;
            S_SWI:   raddr = i_reg;
            S_FIN1:  raddr = i_reg;
            S_ERD:   raddr = emit_reg;
            default: raddr = j_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= mem[raddr];
        stk_top <= stk[IW'(sp_reg - CW'(1))];
        if (state_reg == S_LOAD && in_valid && count_reg < CW'(MAX_KEYS))
            mem[count_reg[IW-1:0]] <= key_bits;
        else if (state_reg == S_SWI && less)
            mem[i_reg] <= aj_reg;
        else if (state_reg == S_SWJ && i_reg != j_reg)
            mem[j_reg] <= rd_reg;
        else if (state_reg == S_FIN2)
            mem[hi_reg] <= rd_reg;
        else if (state_reg == S_PUSH)
            mem[i_reg] <= piv_reg;
        if (state_reg == S_LOAD && in_valid && is_last)
            stk[0] <= {IW'(0), IW'(count_reg - CW'(count_reg < CW'(MAX_KEYS) ? 0 : 1))};
        else if (state_reg == S_PUSH)
        begin
            if (has_l && has_r)
            begin
                if (lsz > rsz)
                begin
                    stk[IW'(sp_reg)] <= {lo_reg, i_reg - IW'(1)};
                    stk[IW'(sp_reg + CW'(1))] <= {i_reg + IW'(1), hi_reg};
                end
                else
                begin
                    stk[IW'(sp_reg)] <= {i_reg + IW'(1), hi_reg};
                    stk[IW'(sp_reg + CW'(1))] <= {lo_reg, i_reg - IW'(1)};
                end
            end
            else if (has_l)
                stk[IW'(sp_reg)] <= {lo_reg, i_reg - IW'(1)};
            else if (has_r)
                stk[IW'(sp_reg)] <= {i_reg + IW'(1), hi_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            ovf_reg <= 1'b0;
            sp_reg <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg <= 1'b0;
            emit_reg <= '0;
            lo_reg <= '0;
            hi_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_valid)
                    begin
                        logic [CW-1:0] n;
                        n = (count_reg < CW'(MAX_KEYS)) ? count_reg + CW'(1) : count_reg;
                        if (count_reg >= CW'(MAX_KEYS))
                            ovf_reg <= 1'b1;
                        count_reg <= n;
                        if (is_last)
                        begin
                            emit_reg <= '0;
                            if (n >= CW'(2))
                            begin
                                sp_reg <= CW'(1);
                                state_reg <= S_POP;
                            end
                            else
                            begin
                                sp_reg <= '0;
                                state_reg <= S_ERD;
                            end
                        end
                    end
                end
                S_POP:
                begin
                    if (sp_reg == '0)
                        state_reg <= S_ERD;
                    else
                        state_reg <= S_RDP;
                end
                S_RDP:
                begin
                    lo_reg <= stk_top[2*IW-1:IW];
                    hi_reg <= stk_top[IW-1:0];
                    i_reg <= stk_top[2*IW-1:IW];
                    j_reg <= stk_top[2*IW-1:IW];
                    sp_reg <= sp_reg - CW'(1);
                    state_reg <= S_PIV;
                end
                S_PIV:
                begin
                    // The pivot word addressed from the stack top arrives now.
                    if (lo_reg >= hi_reg)
                        state_reg <= S_POP;
                    else
                        state_reg <= S_RDJ;
                end
                S_RDJ:
                begin
                    if (j_reg == hi_reg)
                        state_reg <= S_FIN1;
                    else
                        state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    aj_reg <= rd_reg;
                    state_reg <= S_SWI;
                end
                S_SWI:
                begin
                    if (less)
                        state_reg <= S_SWJ;
                    else
                    begin
                        j_reg <= j_reg + IW'(1);
                        state_reg <= S_RDJ;
                    end
                end
                S_SWJ:
                begin
                    i_reg <= i_reg + IW'(1);
                    j_reg <= j_reg + IW'(1);
                    state_reg <= S_RDJ;
                end
                S_FIN1:
                begin
                    state_reg <= S_FIN2;
                end
                S_FIN2:
                begin
                    state_reg <= S_PUSH;
                end
                S_PUSH:
                begin
                    sp_reg <= sp_reg + CW'(has_l) + CW'(has_r);
                    state_reg <= S_POP;
                end
                S_ERD:
                begin
                    if (count_reg == '0)
                        state_reg <= S_LOAD;
                    else
                        state_reg <= S_EWAIT;
                end
                S_EWAIT:
                begin
                    out_valid_reg <= 1'b1;
                    out_last_reg <= (CW'(emit_reg) + CW'(1) == count_reg);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            count_reg <= '0;
                            ovf_reg <= 1'b0;
                            sp_reg <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            emit_reg <= emit_reg + IW'(1);
                            state_reg <= S_ERD;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PIV)
            piv_reg <= rd_reg;
        if (state_reg == S_EWAIT)
            out_key_reg <= rd_reg;
    end

    `include "quicksort_lomuto_engine_assert.svh"

    `QLE_ASSERT_IMPL(a_no_in_while_out, out_valid, !in_ready, "input taken during emission")
    `QLE_ASSERT_IMPL(a_sp_bound, 1'b1, sp_reg <= CW'(MAX_KEYS), "range stack overflow")
    `QLE_ASSERT_NEXT(a_last_clears, out_valid && out_ready && end_of_batch,
        in_ready && !dropped, "batch state not cleared")
endmodule
